// ===== hdl/ohlc_pkg.sv =====
// Shared types and codes for the OHLC bar aggregator.
// Depends on nothing; imported by every module of the block.
package ohlc_pkg;

  localparam int unsigned ACT_BITS = 2;
  localparam int unsigned EV_BITS  = 3;
  localparam int unsigned IVL_BITS = 32;
  localparam logic [IVL_BITS-1:0] IVL_RESET = 32'd60000;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_HIST  = 2'd0,
    ACT_LIVE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [EV_BITS-1:0] {
    EV_OPENED  = 3'd0,
    EV_UPDATED = 3'd1,
    EV_LIVE    = 3'd2,
    EV_CLOSED  = 3'd3,
    EV_CLEARED = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    FS_IDLE = 3'b001,
    FS_DIV  = 3'b010,
    FS_PUSH = 3'b100
  } fstate_e;

endpackage

// ===== hdl/ohlc_front.sv =====
// Front end: accepts ticks, holds the interval register and computes the
// interval floor of the tick time with a bit-serial divider. Uses ohlc_pkg.
module ohlc_front #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ohlc_pkg::IVL_BITS-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ohlc_pkg::ACT_BITS-1:0] in_action_i,
  input  logic [TIME_BITS-1:0]       in_time_i,
  input  logic [VALUE_BITS-1:0]      in_price_i,
  input  logic [VALUE_BITS-1:0]      in_volume_i,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  // {volume, price, interval-1, floor, time, action}
  output logic [ohlc_pkg::ACT_BITS+ohlc_pkg::IVL_BITS+2*TIME_BITS+2*VALUE_BITS-1:0] push_data_o
);
  import ohlc_pkg::*;

  localparam int unsigned CNT_W = $clog2(TIME_BITS);

  fstate_e               state_q, state_d;
  logic [IVL_BITS-1:0]   ivl_q, ivl_d;
  logic [IVL_BITS-1:0]   div_q, div_d;
  logic [IVL_BITS-1:0]   rem_q, rem_d;
  logic [TIME_BITS-1:0]  sh_q, sh_d;
  logic [TIME_BITS-1:0]  time_q, time_d;
  logic [VALUE_BITS-1:0] price_q, price_d;
  logic [VALUE_BITS-1:0] vol_q, vol_d;
  logic [ACT_BITS-1:0]   act_q, act_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [IVL_BITS:0]     rem_sh;
  logic [IVL_BITS:0]     rem_sub;
  logic [TIME_BITS-1:0]  floor_w;
  logic                  accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == FS_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  // One quotient bit per cycle: shift in the next time bit, subtract if it fits.
  assign rem_sh  = {rem_q, sh_q[TIME_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  // A clear carries no floor; the remainder register is zero for it.
  assign floor_w = time_q - TIME_BITS'(rem_q);

  assign push_valid_o = (state_q == FS_PUSH);
  assign push_data_o  = {vol_q, price_q, div_q - IVL_BITS'(1), floor_w, time_q, act_q};

  always_comb begin
    state_d = state_q;
    ivl_d   = ivl_q;
    div_d   = div_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    time_d  = time_q;
    price_d = price_q;
    vol_d   = vol_q;
    act_d   = act_q;
    cnt_d   = cnt_q;
    if (cfg_valid_i) begin
      ivl_d = cfg_data_i;
    end
    case (state_q)
      FS_IDLE: begin
        if (accept) begin
          time_d  = in_time_i;
          sh_d    = in_time_i;
          price_d = in_price_i;
          vol_d   = in_volume_i;
          act_d   = in_action_i;
          rem_d   = '0;
          cnt_d   = '0;
          // Zero interval behaves as one.
          div_d   = (ivl_q == '0) ? IVL_BITS'(1) : ivl_q;
          case (action_e'(in_action_i))
            ACT_HIST, ACT_LIVE: state_d = FS_DIV;
            ACT_CLEAR:          state_d = FS_PUSH;
            default:            state_d = FS_IDLE; // drop unknown action
          endcase
        end
      end
      FS_DIV: begin
        rem_d = rem_sub[IVL_BITS] ? rem_sh[IVL_BITS-1:0] : rem_sub[IVL_BITS-1:0];
        sh_d  = {sh_q[TIME_BITS-2:0], 1'b0};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(TIME_BITS - 1)) begin
          state_d = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (push_ready_i) begin
          state_d = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_IDLE;
      ivl_q   <= IVL_RESET;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ivl_q   <= ivl_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    time_q  <= time_d;
    price_q <= price_d;
    vol_q   <= vol_d;
    act_q   <= act_d;
  end

endmodule

// ===== hdl/ohlc_fifo.sv =====
// Two-entry queue between the front end and the bar update stage.
// Depends on nothing beyond the shared package import.
module ohlc_fifo #(
  parameter int unsigned WIDTH = 290
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  import ohlc_pkg::*;

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      if (do_wr && !do_rd) begin
        count_q <= count_q + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== hdl/ohlc_back.sv =====
// Bar update stage: applies one classified tick to the bar state and holds
// the resulting bar in the output register. Uses ohlc_pkg.
module ohlc_back #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ohlc_pkg::ACT_BITS+ohlc_pkg::IVL_BITS+2*TIME_BITS+2*VALUE_BITS-1:0] in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ohlc_pkg::EV_BITS-1:0] out_event_o,
  output logic [TIME_BITS-1:0]       out_start_o,
  output logic [VALUE_BITS-1:0]      out_open_o,
  output logic [VALUE_BITS-1:0]      out_high_o,
  output logic [VALUE_BITS-1:0]      out_low_o,
  output logic [VALUE_BITS-1:0]      out_close_o,
  output logic [VALUE_BITS-1:0]      out_volume_o
);
  import ohlc_pkg::*;

  logic [ACT_BITS-1:0]   e_act;
  logic [TIME_BITS-1:0]  e_time, e_floor;
  logic [IVL_BITS-1:0]   e_ivm1;
  logic [VALUE_BITS-1:0] e_price, e_vol;

  logic                  present_q, present_d;
  logic                  hist_q, hist_d;
  logic                  live_q, live_d;
  logic                  oval_q, oval_d;
  event_e                ev_q, ev_d;
  logic [TIME_BITS-1:0]  start_q, start_d, lastf_q, lastf_d;
  logic [VALUE_BITS-1:0] open_q, open_d, high_q, high_d, low_q, low_d;
  logic [VALUE_BITS-1:0] close_q, close_d, vol_q, vol_d;

  logic                  pop;
  logic [VALUE_BITS:0]   vsum;
  logic [VALUE_BITS-1:0] m_vol, m_high, m_low;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  hist_end, live_end;

  assign {e_vol, e_price, e_ivm1, e_floor, e_time, e_act} = in_data_i;

  assign pop        = in_valid_i && (!oval_q || out_ready_i);
  assign in_ready_o = !oval_q || out_ready_i;

  // Merged values of the tick into the open bar.
  assign vsum   = {1'b0, vol_q} + {1'b0, e_vol};
  assign m_vol  = vsum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : vsum[VALUE_BITS-1:0];
  assign m_high = (e_price > high_q) ? e_price : high_q;
  assign m_low  = (e_price < low_q) ? e_price : low_q;

  assign elapsed  = e_time - start_q;
  assign hist_end = (e_time >= start_q) && (elapsed >= TIME_BITS'(e_ivm1));
  assign live_end = (e_floor > lastf_q);

  always_comb begin
    present_d = present_q;
    hist_d    = hist_q;
    live_d    = live_q;
    ev_d      = ev_q;
    start_d   = start_q;
    lastf_d   = lastf_q;
    open_d    = open_q;
    high_d    = high_q;
    low_d     = low_q;
    close_d   = close_q;
    vol_d     = vol_q;
    oval_d    = oval_q && !out_ready_i;
    if (pop) begin
      case (action_e'(e_act))
        ACT_HIST, ACT_LIVE: begin
          oval_d = 1'b1;
          if (!present_q || ((action_e'(e_act) == ACT_HIST) ? hist_q : live_q)) begin
            if (action_e'(e_act) == ACT_HIST) hist_d = 1'b0;
            else live_d = 1'b0;
            present_d = 1'b1;
            start_d   = e_floor;
            lastf_d   = e_floor;
            open_d    = e_price;
            high_d    = e_price;
            low_d     = e_price;
            close_d   = e_price;
            vol_d     = e_vol;
            ev_d      = EV_OPENED;
          end else begin
            high_d  = m_high;
            low_d   = m_low;
            close_d = e_price;
            vol_d   = m_vol;
            if (action_e'(e_act) == ACT_HIST) begin
              if (hist_end) begin
                hist_d = 1'b1;
                ev_d   = EV_CLOSED;
              end else begin
                ev_d   = EV_UPDATED;
              end
            end else begin
              if (live_end) begin
                live_d = 1'b1;
                ev_d   = EV_CLOSED;
              end else begin
                ev_d   = EV_LIVE;
              end
            end
          end
        end
        ACT_CLEAR: begin
          // Drop the bar; keep the live close flag and last floor.
          oval_d    = 1'b1;
          present_d = 1'b0;
          hist_d    = 1'b0;
          start_d   = '0;
          open_d    = '0;
          high_d    = '0;
          low_d     = '0;
          close_d   = '0;
          vol_d     = '0;
          ev_d      = EV_CLEARED;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
      hist_q    <= 1'b0;
      live_q    <= 1'b0;
      oval_q    <= 1'b0;
      ev_q      <= EV_OPENED;
      start_q   <= '0;
      lastf_q   <= '0;
      open_q    <= '0;
      high_q    <= '0;
      low_q     <= '0;
      close_q   <= '0;
      vol_q     <= '0;
    end else begin
      present_q <= present_d;
      hist_q    <= hist_d;
      live_q    <= live_d;
      oval_q    <= oval_d;
      ev_q      <= ev_d;
      start_q   <= start_d;
      lastf_q   <= lastf_d;
      open_q    <= open_d;
      high_q    <= high_d;
      low_q     <= low_d;
      close_q   <= close_d;
      vol_q     <= vol_d;
    end
  end

  // State only moves when the output register is free, so it doubles as the result.
  assign out_valid_o  = oval_q;
  assign out_event_o  = ev_q;
  assign out_start_o  = start_q;
  assign out_open_o   = open_q;
  assign out_high_o   = high_q;
  assign out_low_o    = low_q;
  assign out_close_o  = close_q;
  assign out_volume_o = vol_q;

endmodule

// ===== hdl/ohlc_bar_aggregator.sv =====
// OHLC bar aggregator: top level, wires front end, queue and bar update stage.
// Depends on ohlc_pkg, ohlc_front, ohlc_fifo and ohlc_back.
//
// Usage:
//   s_axis carries one tick per transfer: tuser is the action (historical
//   tick, live tick, clear), tdata the time, price and volume. m_axis gives
//   one bar per tick (none for the unused action code): tuser is the event,
//   tdata the bar start and open/high/low/close/volume after the tick.
//   cfg_* writes the interval in ms; write it only while the block is idle.
//   A tick passes the bit-serial floor divider, which works through one time
//   bit per step, then the queue, then the bar register, before its bar is
//   valid on m_axis; a clear skips the divider.
//   Throughput: the front end holds s_axis_tready low while the divider runs
//   and until its entry is pushed, so ticks and clears are taken only once the
//   last one has left it, and the unused code every cycle while it is idle.
//   The bar stage takes one entry per cycle while m_axis is not stalled.
//   Reset clears the bar state, the queue and the output, and loads the
//   interval with 60000. A stalled receiver holds the result in the output
//   register; two more bars wait in the queue, a third finished tick waits
//   in the front end, and s_axis_tready then stays low until m_axis moves.
module ohlc_bar_aggregator #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ohlc_pkg::IVL_BITS-1:0] cfg_data_i,   // interval_ms
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tick_time_ms, tick_price, tick_volume (lowest bit up), zero padded
  input  logic [((TIME_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic [ohlc_pkg::ACT_BITS-1:0] s_axis_tuser, // action
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // bar_start_ms, bar_open, bar_high, bar_low, bar_close, bar_volume
  // (lowest bit up), zero padded
  output logic [((TIME_BITS+5*VALUE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic [ohlc_pkg::EV_BITS-1:0] m_axis_tuser   // event_res
);
  import ohlc_pkg::*;

  localparam int unsigned ENTRY_W = ACT_BITS + IVL_BITS + 2*TIME_BITS + 2*VALUE_BITS;
  localparam int unsigned OUT_W   = TIME_BITS + 5*VALUE_BITS;
  localparam int unsigned OUT_TW  = ((OUT_W + 7) / 8) * 8;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]    push_data, pop_data;
  logic [TIME_BITS-1:0]  bar_start;
  logic [VALUE_BITS-1:0] bar_open, bar_high, bar_low, bar_close, bar_volume;

  ohlc_front #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_action_i  (s_axis_tuser),
    .in_time_i    (s_axis_tdata[TIME_BITS-1:0]),
    .in_price_i   (s_axis_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS]),
    .in_volume_i  (s_axis_tdata[TIME_BITS+2*VALUE_BITS-1:TIME_BITS+VALUE_BITS]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple the divider from a stalled bar stage.
  ohlc_fifo #(
    .WIDTH (ENTRY_W)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  ohlc_back #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (pop_valid),
    .in_ready_o   (pop_ready),
    .in_data_i    (pop_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_event_o  (m_axis_tuser),
    .out_start_o  (bar_start),
    .out_open_o   (bar_open),
    .out_high_o   (bar_high),
    .out_low_o    (bar_low),
    .out_close_o  (bar_close),
    .out_volume_o (bar_volume)
  );

  // Pack the bar, start time in the lowest bits; pad up to whole bytes.
  assign m_axis_tdata = OUT_TW'({bar_volume, bar_close, bar_low, bar_high, bar_open,
                                 bar_start});

endmodule

// ===== tb/ohlc_bar_checker.sv =====
// Checker for the OHLC bar aggregator: tracks the bar state from the tick
// and interval transfers it sees and compares every bar transfer with it.
// Depends on ohlc_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 100ps
module ohlc_bar_checker #(
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned VALUE_BITS = 48
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  input  logic                                        cfg_ready_i,
  input  logic [ohlc_pkg::IVL_BITS-1:0]               cfg_data_i,
  input  logic                                        s_tvalid_i,
  input  logic                                        s_tready_i,
  // tick_time_ms, tick_price, tick_volume (lowest bit up), zero padded
  input  logic [((TIME_BITS+2*VALUE_BITS+7)/8)*8-1:0] s_tdata_i,
  input  logic [ohlc_pkg::ACT_BITS-1:0]               s_tuser_i,  // action
  input  logic                                        m_tvalid_i,
  input  logic                                        m_tready_i,
  // bar_start_ms, bar_open, bar_high, bar_low, bar_close, bar_volume
  // (lowest bit up), zero padded
  input  logic [((TIME_BITS+5*VALUE_BITS+7)/8)*8-1:0] m_tdata_i,
  input  logic [ohlc_pkg::EV_BITS-1:0]                m_tuser_i,  // event_res
  output int unsigned                                 fail_count_o,
  output int unsigned                                 pending_o,
  output int unsigned                                 checked_o
);
  import ohlc_pkg::*;

  typedef struct packed {
    event_e                ev;
    logic [TIME_BITS-1:0]  start_ms;
    logic [VALUE_BITS-1:0] open_px;
    logic [VALUE_BITS-1:0] high_px;
    logic [VALUE_BITS-1:0] low_px;
    logic [VALUE_BITS-1:0] close_px;
    logic [VALUE_BITS-1:0] vol_sum;
  } bar_t;

  logic [IVL_BITS-1:0]   interval;
  bit                    bar_present;
  bit                    hist_closed;
  bit                    live_closed;
  logic [TIME_BITS-1:0]  start_ms;
  logic [TIME_BITS-1:0]  last_floor;
  logic [VALUE_BITS-1:0] open_px, high_px, low_px, close_px, vol_sum;
  bar_t                  bars_due[$];

  // A zero interval behaves as one millisecond.
  function automatic logic [TIME_BITS-1:0] bar_span();
    logic [TIME_BITS-1:0] span;
    span = TIME_BITS'(interval);
    if (interval == '0) span = TIME_BITS'(1);
    return span;
  endfunction

  function automatic logic [TIME_BITS-1:0] interval_floor(input logic [TIME_BITS-1:0] t);
    return t - (t % bar_span());
  endfunction

  task automatic open_bar(input logic [TIME_BITS-1:0] t,
                          input logic [VALUE_BITS-1:0] p, input logic [VALUE_BITS-1:0] v);
    bar_present = 1'b1;
    start_ms    = interval_floor(t);
    last_floor  = start_ms;
    open_px     = p;
    high_px     = p;
    low_px      = p;
    close_px    = p;
    vol_sum     = v;
  endtask

  task automatic merge_tick(input logic [VALUE_BITS-1:0] p, input logic [VALUE_BITS-1:0] v);
    logic [VALUE_BITS:0] sum;
    sum     = {1'b0, vol_sum} + {1'b0, v};
    vol_sum = sum[VALUE_BITS] ? '1 : sum[VALUE_BITS-1:0];
    if (p > high_px) high_px = p;
    if (p < low_px) low_px = p;
    close_px = p;
  endtask

  task automatic apply_tick(input logic [ACT_BITS-1:0] act, input logic [TIME_BITS-1:0] t,
                            input logic [VALUE_BITS-1:0] p, input logic [VALUE_BITS-1:0] v);
    event_e ev;
    case (act)
      ACT_HIST: begin
        if (!bar_present || hist_closed) begin
          hist_closed = 1'b0;
          open_bar(t, p, v);
          ev = EV_OPENED;
        end else if (t >= start_ms && (t - start_ms) >= bar_span() - TIME_BITS'(1)) begin
          hist_closed = 1'b1;
          merge_tick(p, v);
          ev = EV_CLOSED;
        end else begin
          merge_tick(p, v);
          ev = EV_UPDATED;
        end
      end
      ACT_LIVE: begin
        if (!bar_present || live_closed) begin
          live_closed = 1'b0;
          open_bar(t, p, v);
          ev = EV_OPENED;
        end else if (interval_floor(t) > last_floor) begin
          live_closed = 1'b1;
          merge_tick(p, v);
          ev = EV_CLOSED;
        end else begin
          merge_tick(p, v);
          ev = EV_LIVE;
        end
      end
      ACT_CLEAR: begin
        // live flag and last floor survive a clear
        bar_present = 1'b0;
        hist_closed = 1'b0;
        start_ms    = '0;
        open_px     = '0;
        high_px     = '0;
        low_px      = '0;
        close_px    = '0;
        vol_sum     = '0;
        ev          = EV_CLEARED;
      end
      default: return;  // unused code: dropped, no bar
    endcase
    bars_due.push_back(bar_t'{ev, start_ms, open_px, high_px, low_px, close_px, vol_sum});
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_bar();
    bar_t want;
    if (bars_due.size() == 0) begin
      $error("bar transfer with no tick waiting: event_res expected none, actual %0d",
             m_tuser_i);
      fail_count_o++;
    end else begin
      want = bars_due.pop_front();
      cmp_field("event_res", 64'(want.ev), 64'(m_tuser_i));
      cmp_field("bar_start_ms", 64'(want.start_ms), 64'(m_tdata_i[TIME_BITS-1:0]));
      cmp_field("bar_open", 64'(want.open_px), 64'(m_tdata_i[TIME_BITS +: VALUE_BITS]));
      cmp_field("bar_high", 64'(want.high_px),
                64'(m_tdata_i[TIME_BITS+VALUE_BITS +: VALUE_BITS]));
      cmp_field("bar_low", 64'(want.low_px),
                64'(m_tdata_i[TIME_BITS+2*VALUE_BITS +: VALUE_BITS]));
      cmp_field("bar_close", 64'(want.close_px),
                64'(m_tdata_i[TIME_BITS+3*VALUE_BITS +: VALUE_BITS]));
      cmp_field("bar_volume", 64'(want.vol_sum),
                64'(m_tdata_i[TIME_BITS+4*VALUE_BITS +: VALUE_BITS]));
      checked_o++;
    end
  endtask

  // Retire a bar before taking a new tick: a bar leaving this cycle always
  // belongs to an older tick.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval     = IVL_RESET;
      bar_present  = 1'b0;
      hist_closed  = 1'b0;
      live_closed  = 1'b0;
      start_ms     = '0;
      last_floor   = '0;
      open_px      = '0;
      high_px      = '0;
      low_px       = '0;
      close_px     = '0;
      vol_sum      = '0;
      bars_due.delete();
      fail_count_o = 0;
      checked_o    = 0;
      pending_o    = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_bar();
      if (cfg_valid_i && cfg_ready_i) interval = cfg_data_i;
      if (s_tvalid_i && s_tready_i)
        apply_tick(s_tuser_i, s_tdata_i[TIME_BITS-1:0], s_tdata_i[TIME_BITS +: VALUE_BITS],
                   s_tdata_i[TIME_BITS+VALUE_BITS +: VALUE_BITS]);
      pending_o = bars_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the OHLC bar aggregator: clock, reset, tick and interval
// stimulus, receiver stalls, watchdog and verdict.
// Depends on ohlc_pkg, ohlc_bar_aggregator and ohlc_bar_checker.
`timescale 1ns / 100ps
module tb_top;
  import ohlc_pkg::*;

  localparam int unsigned TIME_BITS  = 48;
  localparam int unsigned VALUE_BITS = 48;
  localparam int unsigned S_W = ((TIME_BITS+2*VALUE_BITS+7)/8)*8;
  localparam int unsigned M_W = ((TIME_BITS+5*VALUE_BITS+7)/8)*8;

  localparam int unsigned MAX_GAP      = 18;    // longest idle draw per item
  localparam int unsigned HOLD_CYCLES  = 600;   // one long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 120;   // > one tick through the divider
  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no transfer at all
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_TICKS  = 53;

  // Action code that the block drops without a bar.
  localparam logic [ACT_BITS-1:0] ACT_UNUSED = 2'd3;

  localparam logic [TIME_BITS-1:0]  T_MAX = '1;
  localparam logic [VALUE_BITS-1:0] V_MAX = '1;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [IVL_BITS-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_W-1:0]      s_axis_tdata = '0;      // time, price, volume
  logic [ACT_BITS-1:0] s_axis_tuser = '0;      // action
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_W-1:0]      m_axis_tdata;           // start, open, high, low, close, volume
  logic [EV_BITS-1:0]  m_axis_tuser;           // event_res

  int unsigned chk_fails, chk_pending, chk_checked;

  // Knobs shared between the tick sender and the bar receiver.
  bit no_idle   = 1'b0;   // both sides run without gaps
  bit hold_req  = 1'b0;   // sender asks the receiver for the long hold-off
  bit hold_done = 1'b0;

  // Stimulus bookkeeping.
  logic [IVL_BITS-1:0]   cur_ivl = IVL_RESET;
  logic [TIME_BITS-1:0]  cur_t = '0;
  logic [VALUE_BITS-1:0] px_cur = '0;
  int unsigned n_ticks = 0, n_clears = 0, n_unused = 0, n_settings = 0;
  int unsigned quiet_cycles = 0;

  always #5 clk = ~clk;

  ohlc_bar_aggregator #(
    .TIME_BITS (TIME_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  ohlc_bar_checker #(
    .TIME_BITS (TIME_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .fail_count_o(chk_fails),
    .pending_o   (chk_pending),
    .checked_o   (chk_checked)
  );

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Bar receiver: random stall before each transfer, one long hold-off on
  // request so the queue fills and s_axis_tready drops.
  initial begin : bar_receiver
    int unsigned stall;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one tick after a random gap and hold it until the transfer.
  // Entered and left at a falling edge; valid stays high across back-to-back
  // ticks.
  task automatic send_tick(input logic [ACT_BITS-1:0] act, input logic [TIME_BITS-1:0] t,
                           input logic [VALUE_BITS-1:0] p, input logic [VALUE_BITS-1:0] v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {v, p, t};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    n_ticks++;
    if (act == ACT_CLEAR) n_clears++;
    if (act == ACT_UNUSED) n_unused++;
  endtask

  // Write the interval only once the block is idle: drain every bar, then
  // give a dropped tick time to leave the front end.
  task automatic write_interval(input logic [IVL_BITS-1:0] ivl);
    s_axis_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= ivl;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    @(negedge clk);
    cfg_valid_i <= 1'b0;
    cur_ivl = ivl;
    n_settings++;
  endtask

  // Random ticks that walk forward through bars of the current interval,
  // with boundary hits, late ticks, jumps and a share of clears and noise.
  task automatic random_ticks(input int unsigned count, input logic [ACT_BITS-1:0] pref);
    logic [TIME_BITS-1:0]  span;
    logic [VALUE_BITS-1:0] delta, vol;
    logic [ACT_BITS-1:0]   act, other;
    int unsigned           upper, r;
    span = TIME_BITS'(cur_ivl);
    if (cur_ivl == '0) span = TIME_BITS'(1);
    upper = 32'(span / TIME_BITS'(3) + TIME_BITS'(1));
    other = (pref == ACT_HIST) ? ACT_LIVE : ACT_HIST;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) act = pref;
      else if (r < 86) act = other;
      else if (r < 94) act = ACT_CLEAR;
      else act = ACT_UNUSED;

      r = $urandom_range(0, 99);
      if (r < 68) cur_t = cur_t + TIME_BITS'($urandom_range(0, upper));
      else if (r < 80) cur_t = cur_t - (cur_t % span) + span - TIME_BITS'(1);  // last ms of the bar
      else if (r < 88) cur_t = cur_t - TIME_BITS'($urandom_range(0, upper));   // late tick
      else if (r < 95) cur_t = cur_t + span;                                   // next bar
      else cur_t = TIME_BITS'({$urandom, $urandom});

      r = $urandom_range(0, 99);
      if (r < 80) begin
        delta  = VALUE_BITS'($urandom_range(0, 8192));
        px_cur = px_cur + delta - VALUE_BITS'(4096);
      end else if (r < 85) px_cur = '0;
      else if (r < 90) px_cur = V_MAX;
      else px_cur = VALUE_BITS'({$urandom, $urandom});

      r = $urandom_range(0, 99);
      if (r < 75) vol = VALUE_BITS'($urandom_range(0, 1 << 20));
      else if (r < 88) vol = V_MAX - VALUE_BITS'($urandom_range(0, 1000));  // drive the sum to saturation
      else vol = VALUE_BITS'({$urandom, $urandom});

      send_tick(act, cur_t, px_cur, vol);
    end
  endtask

  initial begin : tick_source
    logic [IVL_BITS-1:0] phase_ivl[PHASES];
    phase_ivl[0] = 32'd7;
    phase_ivl[1] = 32'd100;
    phase_ivl[2] = 32'd1;
    phase_ivl[3] = IVL_RESET;
    phase_ivl[4] = 32'd3;
    phase_ivl[5] = '1;
    phase_ivl[6] = $urandom_range(1000, 100000);
    phase_ivl[7] = $urandom_range(2, 50);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed ticks at the reset interval of 60000 ms.
    send_tick(ACT_CLEAR, '0, '0, '0);                        // clear with no bar
    send_tick(ACT_HIST, 48'd120005, 48'd100 << 16, 48'd1 << 16);
    send_tick(ACT_HIST, 48'd150000, V_MAX, V_MAX);           // volume saturates
    send_tick(ACT_HIST, 48'd5, '0, '0);                      // tick before bar start
    send_tick(ACT_HIST, 48'd179999, 48'd50 << 16, 48'd3);    // last ms closes
    send_tick(ACT_HIST, 48'd179000, 48'd20 << 16, 48'd1);    // reopen after close
    send_tick(ACT_UNUSED, T_MAX, V_MAX, V_MAX);              // dropped
    send_tick(ACT_LIVE, 48'd179500, 48'd7, 48'd2);           // silent update
    send_tick(ACT_LIVE, 48'd180000, 48'd9, 48'd1);           // later floor closes
    send_tick(ACT_CLEAR, T_MAX, V_MAX, V_MAX);               // live flag survives
    send_tick(ACT_HIST, T_MAX, 48'd1, 48'd2);
    send_tick(ACT_LIVE, '0, 48'd3, 48'd4);                   // opens on stale live flag
    send_tick(ACT_LIVE, T_MAX, 48'd6, 48'd7);

    // One-millisecond bars: every second tick closes.
    write_interval(32'd1);
    send_tick(ACT_HIST, 48'd10, 48'd11, 48'd1);
    send_tick(ACT_HIST, 48'd10, 48'd12, 48'd1);
    send_tick(ACT_HIST, 48'd10, 48'd13, 48'd1);
    send_tick(ACT_LIVE, 48'd3, 48'd14, 48'd1);
    send_tick(ACT_LIVE, 48'd4, 48'd15, 48'd1);

    // Zero interval acts as one millisecond.
    write_interval('0);
    send_tick(ACT_HIST, 48'd7, 48'd16, 48'd1);
    send_tick(ACT_HIST, 48'd7, 48'd17, 48'd1);
    send_tick(ACT_LIVE, 48'd8, 48'd18, 48'd1);
    send_tick(ACT_LIVE, 48'd9, 48'd19, 48'd1);

    // Widest interval.
    write_interval('1);
    send_tick(ACT_HIST, T_MAX, V_MAX, 48'd1);
    send_tick(ACT_HIST, '0, '0, 48'd1);

    // Random phases, each under its own interval; alternate the favored
    // tick kind, run one phase with no gaps and hold the receiver in another.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_interval(phase_ivl[ph]);
      cur_t  = TIME_BITS'({$urandom_range(0, 65535), $urandom});
      px_cur = VALUE_BITS'({$urandom_range(0, 65535), $urandom});
      no_idle = (ph == 3);
      if (ph == 1) hold_req = 1'b1;
      random_ticks(PHASE_TICKS, ph[0] ? ACT_LIVE : ACT_HIST);
    end
    no_idle = 1'b0;

    // Drain and settle.
    s_axis_tvalid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run sent %0d ticks (%0d clears, %0d dropped codes) under %0d interval settings.",
             n_ticks, n_clears, n_unused, n_settings);
    $display("Compared %0d bars field by field; %0d mismatches.", chk_checked, chk_fails);
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
